// ===== src/sha1_message_digest_core_assert.svh =====
// ----------------------------------------------------------------------------
// SHA-1 digest core assertion macros
// Shared property templates for the digest core checks.
// ----------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_CORE_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SHA1MD_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SHA1MD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/sha1md_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1md_pkg
// Types, constants and round functions shared by the SHA-1 digest core.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1md_pkg;

   localparam int WORD_W      = 32;
   localparam int NUM_CHAIN   = 5;
   localparam int WIN_WORDS   = 16;
   localparam int BLOCK_W     = WORD_W * WIN_WORDS;

   typedef logic [WORD_W-1:0]              word_type;
   typedef logic [NUM_CHAIN-1:0][WORD_W-1:0] chain_type;
   typedef logic [6:0]                     round_type;
   typedef logic [5:0]                     pos_type;
   typedef logic [2:0]                     widx_type;
   typedef logic [63:0]                    len_type;

   // Chaining value after reset, element 0 is H0
   localparam chain_type IV_WORDS = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                     32'hEFCDAB89, 32'h67452301};

   localparam round_type LAST_ROUND     = 7'd79;
   localparam pos_type   LAST_BYTE_POS  = 6'd63;
   localparam pos_type   LEN_FIELD_POS  = 6'd56;   // 448 bits into the block
   localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
   localparam logic [2:0] LAST_LEN_BYTE = 3'd7;
   localparam widx_type  LAST_WORD_IDX  = 3'd4;
   localparam len_type   BYTE_BITS      = 64'd8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADD,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_OUT
   } state_type;

   // Control to the message schedule window
   typedef struct packed {
      logic       push;
      logic [7:0] data;
      logic       step;
   } sched_ctl_type;

   // Control to the round datapath
   typedef struct packed {
      logic init;
      logic load;
      logic step;
      logic add;
   } round_ctl_type;

   // Round constant for round t
   function automatic word_type round_k(input round_type t);
      word_type k;
      priority if (t < 7'd20) k = 32'h5A827999;
      else if (t < 7'd40)     k = 32'h6ED9EBA1;
      else if (t < 7'd60)     k = 32'h8F1BBCDC;
      else                    k = 32'hCA62C1D6;
      return k;
   endfunction

   // Boolean function for round t
   function automatic word_type round_f(input round_type t, input word_type b,
                                        input word_type c, input word_type d);
      word_type f;
      priority if (t < 7'd20) f = (b & c) | (~b & d);
      else if (t < 7'd40)     f = b ^ c ^ d;
      else if (t < 7'd60)     f = (b & c) | (b & d) | (c & d);
      else                    f = b ^ c ^ d;
      return f;
   endfunction

endpackage

`default_nettype wire

// ===== src/sha1md_sched.sv =====
// ----------------------------------------------------------------------------
// sha1md_sched
// 512-bit message window: bytes shift in big-endian, then each round shifts
// one word out and appends the next expanded schedule word.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1md_sched (
   input  wire logic                   clock,
   input  wire sha1md_pkg::sched_ctl_type ctl,
   output sha1md_pkg::word_type        w_cur
);

   logic [sha1md_pkg::BLOCK_W-1:0] win_ff;
   logic [sha1md_pkg::BLOCK_W-1:0] win_in;
   sha1md_pkg::word_type           w_mix;
   sha1md_pkg::word_type           w_new;

   // Word j of the window sits at the top minus j words
   assign w_cur = win_ff[sha1md_pkg::BLOCK_W-1 -: sha1md_pkg::WORD_W];

   // W[t+16] = rotl1(W[t+13] ^ W[t+8] ^ W[t+2] ^ W[t])
   always_comb begin
      w_mix = win_ff[sha1md_pkg::BLOCK_W-1-13*sha1md_pkg::WORD_W -: sha1md_pkg::WORD_W]
            ^ win_ff[sha1md_pkg::BLOCK_W-1-8*sha1md_pkg::WORD_W  -: sha1md_pkg::WORD_W]
            ^ win_ff[sha1md_pkg::BLOCK_W-1-2*sha1md_pkg::WORD_W  -: sha1md_pkg::WORD_W]
            ^ w_cur;
      w_new = {w_mix[sha1md_pkg::WORD_W-2:0], w_mix[sha1md_pkg::WORD_W-1]};
   end

   // Byte push or word shift
   always_comb begin
      win_in = win_ff;
      priority if (ctl.push) begin
         win_in = {win_ff[sha1md_pkg::BLOCK_W-9:0], ctl.data};
      end else if (ctl.step) begin
         win_in = {win_ff[sha1md_pkg::BLOCK_W-sha1md_pkg::WORD_W-1:0], w_new};
      end
   end

   // Payload storage, no reset needed
   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

`default_nettype wire

// ===== src/sha1md_round.sv =====
// ----------------------------------------------------------------------------
// sha1md_round
// Working words a..e with the shared round adder, and the chaining words
// that collect each block's result.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1md_round (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire sha1md_pkg::round_ctl_type ctl,
   input  wire sha1md_pkg::round_type   round_t,
   input  wire sha1md_pkg::word_type    w_cur,
   output sha1md_pkg::chain_type        chain
);

   sha1md_pkg::chain_type chain_ff;
   sha1md_pkg::chain_type chain_in;
   sha1md_pkg::chain_type work_ff;
   sha1md_pkg::chain_type work_in;
   sha1md_pkg::word_type  a, b, c, d, e;
   sha1md_pkg::word_type  tmp;

   assign chain = chain_ff;
   assign a = work_ff[0];
   assign b = work_ff[1];
   assign c = work_ff[2];
   assign d = work_ff[3];
   assign e = work_ff[4];

   // One round: rotl(a,5) + f + e + K + W
   assign tmp = {a[26:0], a[31:27]} + sha1md_pkg::round_f(round_t, b, c, d) + e
              + sha1md_pkg::round_k(round_t) + w_cur;

   // Working words
   always_comb begin
      work_in = work_ff;
      priority if (ctl.load) begin
         work_in = chain_ff;
      end else if (ctl.step) begin
         work_in[0] = tmp;
         work_in[1] = a;
         work_in[2] = {b[1:0], b[31:2]};
         work_in[3] = c;
         work_in[4] = d;
      end
   end

   // Chaining words: restart or fold in the block result
   always_comb begin
      chain_in = chain_ff;
      priority if (ctl.init) begin
         chain_in = sha1md_pkg::IV_WORDS;
      end else if (ctl.add) begin
         for (int i = 0; i < sha1md_pkg::NUM_CHAIN; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= sha1md_pkg::IV_WORDS;
      end else begin
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

endmodule

`default_nettype wire

// ===== src/sha1_message_digest_core.sv =====
// ----------------------------------------------------------------------------
// sha1_message_digest_core
// SHA-1 over a byte stream: length counting, padding, 80-round compression
// per 64-byte block and a five-word digest on the end-of-message item.
//
//   channel  dir  handshake            payload
//   req_     in   req_valid/req_stall  data_byte, byte_valid, end_of_message
//   rsp_     out  rsp_valid/rsp_stall  digest_word, word_index, last_word
//
// A byte that fills a 64-byte block starts a compression: 80 rounds
// through the single round adder, then the chaining add.
// An end item pads one byte per cycle, pausing in ST_PAD_ZERO before the
// length field, with one or two more compressions, then offers five digest
// items; req_stall stays high until the last is taken.
// Synchronous reset returns control state and chaining words to their start.
// rsp_stall only holds the current digest item; it never loses state.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_message_digest_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_valid,
   input  wire logic        req_end_of_message,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);

`include "sha1_message_digest_core_assert.svh"

   sha1md_pkg::state_type     state_ff, state_in;
   sha1md_pkg::state_type     resume_ff, resume_in;
   sha1md_pkg::pos_type       pos_ff, pos_in;
   sha1md_pkg::len_type       len_ff, len_in;
   sha1md_pkg::round_type     round_ff, round_in;
   logic [2:0]                len_cnt_ff, len_cnt_in;
   sha1md_pkg::widx_type      out_cnt_ff, out_cnt_in;

   sha1md_pkg::sched_ctl_type sched_ctl;
   sha1md_pkg::round_ctl_type round_ctl;
   sha1md_pkg::word_type      w_cur;
   sha1md_pkg::chain_type     chain;

   logic req_acc;
   logic rsp_acc;
   logic wrap;
   logic out_done;

   assign req_acc  = req_valid && !req_stall;
   assign rsp_acc  = rsp_valid && !rsp_stall;
   assign wrap     = sched_ctl.push && (pos_ff == sha1md_pkg::LAST_BYTE_POS);
   assign out_done = rsp_acc && (out_cnt_ff == sha1md_pkg::LAST_WORD_IDX);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha1md_pkg::ST_IDLE: begin
            if (req_acc) begin
               priority if (wrap)             state_in = sha1md_pkg::ST_ROUND;
               else if (req_end_of_message)   state_in = sha1md_pkg::ST_PAD_MARK;
               else                           state_in = sha1md_pkg::ST_IDLE;
            end
         end
         sha1md_pkg::ST_ROUND: begin
            if (round_ff == sha1md_pkg::LAST_ROUND) state_in = sha1md_pkg::ST_ADD;
         end
         sha1md_pkg::ST_ADD: begin
            state_in = resume_ff;
         end
         sha1md_pkg::ST_PAD_MARK: begin
            state_in = wrap ? sha1md_pkg::ST_ROUND : sha1md_pkg::ST_PAD_ZERO;
         end
         sha1md_pkg::ST_PAD_ZERO: begin
            priority if (pos_ff == sha1md_pkg::LEN_FIELD_POS)
               state_in = sha1md_pkg::ST_PAD_LEN;
            else if (wrap)
               state_in = sha1md_pkg::ST_ROUND;
            else
               state_in = sha1md_pkg::ST_PAD_ZERO;
         end
         sha1md_pkg::ST_PAD_LEN: begin
            if (wrap) state_in = sha1md_pkg::ST_ROUND;
         end
         sha1md_pkg::ST_OUT: begin
            if (out_done) state_in = sha1md_pkg::ST_IDLE;
         end
         default: state_in = sha1md_pkg::ST_IDLE;
      endcase
   end

   // State outputs: byte feed, round control, handshakes
   always_comb begin
      sched_ctl = '0;
      round_ctl = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         sha1md_pkg::ST_IDLE: begin
            req_stall      = 1'b0;
            sched_ctl.push = req_acc && req_byte_valid;
            sched_ctl.data = req_data_byte;
         end
         sha1md_pkg::ST_ROUND: begin
            sched_ctl.step = 1'b1;
            round_ctl.step = 1'b1;
         end
         sha1md_pkg::ST_ADD: begin
            round_ctl.add = 1'b1;
         end
         sha1md_pkg::ST_PAD_MARK: begin
            sched_ctl.push = 1'b1;
            sched_ctl.data = sha1md_pkg::PAD_MARK_BYTE;
         end
         sha1md_pkg::ST_PAD_ZERO: begin
            sched_ctl.push = (pos_ff != sha1md_pkg::LEN_FIELD_POS);
            sched_ctl.data = 8'h00;
         end
         sha1md_pkg::ST_PAD_LEN: begin
            // Length goes out most significant byte first
            sched_ctl.push = 1'b1;
            sched_ctl.data = len_ff[{~len_cnt_ff, 3'b000} +: 8];
         end
         sha1md_pkg::ST_OUT: begin
            rsp_valid      = 1'b1;
            round_ctl.init = out_done;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
      // Working words load from the chain as a block completes
      round_ctl.load = wrap;
   end

   // Counters and length
   always_comb begin
      pos_in     = pos_ff;
      len_in     = len_ff;
      round_in   = round_ff;
      len_cnt_in = len_cnt_ff;
      out_cnt_in = out_cnt_ff;
      resume_in  = resume_ff;

      if (sched_ctl.push) pos_in = pos_ff + 6'd1;
      if (req_acc && req_byte_valid) len_in = len_ff + sha1md_pkg::BYTE_BITS;
      if (out_done) len_in = '0;

      if (state_ff == sha1md_pkg::ST_ROUND) begin
         round_in = (round_ff == sha1md_pkg::LAST_ROUND) ? 7'd0 : round_ff + 7'd1;
      end
      if (state_ff == sha1md_pkg::ST_PAD_LEN) len_cnt_in = len_cnt_ff + 3'd1;
      if (rsp_acc) begin
         out_cnt_in = out_done ? 3'd0 : out_cnt_ff + 3'd1;
      end

      // Where to continue after the block's chaining add
      if (wrap) begin
         unique case (state_ff)
            sha1md_pkg::ST_IDLE:
               resume_in = req_end_of_message ? sha1md_pkg::ST_PAD_MARK
                                              : sha1md_pkg::ST_IDLE;
            sha1md_pkg::ST_PAD_LEN: resume_in = sha1md_pkg::ST_OUT;
            default:                resume_in = sha1md_pkg::ST_PAD_ZERO;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sha1md_pkg::ST_IDLE;
         resume_ff  <= sha1md_pkg::ST_IDLE;
         pos_ff     <= '0;
         len_ff     <= '0;
         round_ff   <= '0;
         len_cnt_ff <= '0;
         out_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         resume_ff  <= resume_in;
         pos_ff     <= pos_in;
         len_ff     <= len_in;
         round_ff   <= round_in;
         len_cnt_ff <= len_cnt_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   sha1md_sched u_sched (
      .clock (clock),
      .ctl   (sched_ctl),
      .w_cur (w_cur)
   );

   sha1md_round u_round (
      .clock   (clock),
      .reset   (reset),
      .ctl     (round_ctl),
      .round_t (round_ff),
      .w_cur   (w_cur),
      .chain   (chain)
   );

   // Digest items straight from the chaining words
   assign rsp_digest_word = chain[out_cnt_ff];
   assign rsp_word_index  = out_cnt_ff;
   assign rsp_last_word   = (out_cnt_ff == sha1md_pkg::LAST_WORD_IDX);

   // Checks
   `SHA1MD_ASSERT_IMPL(a_no_req_during_rsp, clock, reset, rsp_valid, req_stall, "input taken while digest pending")
   `SHA1MD_ASSERT_IMPL(a_out_block_aligned, clock, reset, state_ff == sha1md_pkg::ST_OUT, pos_ff == 6'd0, "digest offered mid-block")
   `SHA1MD_ASSERT_NEXT(a_rounds_run, clock, reset, (state_ff == sha1md_pkg::ST_ROUND) && (round_ff != sha1md_pkg::LAST_ROUND), state_ff == sha1md_pkg::ST_ROUND, "round loop left early")
   `SHA1MD_ASSERT_IMPL(a_last_word_idx, clock, reset, rsp_valid && rsp_last_word, rsp_word_index == sha1md_pkg::LAST_WORD_IDX, "last flag on wrong word")

endmodule

`default_nettype wire
